// ===== rtl/core/priority_active_expired_scheduler_defines.svh =====
// assertion macros used by the checker in paee_checker.sv
`ifndef PRIORITY_ACTIVE_EXPIRED_SCHEDULER_DEFINES_SVH
`define PRIORITY_ACTIVE_EXPIRED_SCHEDULER_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define PAEE_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define PAEE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that is checked during reset too
`define PAEE_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/paee_pkg.sv =====
package paee_pkg;

    localparam int TAG_W    = 16;
    localparam int DYN_IN_W = 5;
    localparam int STAT_W   = 5;
    localparam int GDYN_W   = 4;

    localparam logic KIND_ADD  = 1'b0;
    localparam logic KIND_TAKE = 1'b1;

    typedef enum logic [2:0] {
        ST_QUEUED_ACTIVE  = 3'd0,
        ST_QUEUED_EXPIRED = 3'd1,
        ST_DROPPED        = 3'd2,
        ST_GRANTED        = 3'd3,
        ST_EMPTY          = 3'd4
    } status_t;

    typedef struct packed {
        logic                       kind;
        logic [TAG_W-1:0]           tag;
        logic signed [DYN_IN_W-1:0] dyn;
        logic [STAT_W-1:0]          stat;
    } item_t;

    typedef struct packed {
        status_t            status;
        logic [TAG_W-1:0]   tag;
        logic [GDYN_W-1:0]  dyn;
        logic [STAT_W-1:0]  stat;
    } result_t;

endpackage

// ===== rtl/core/paee_ram.sv =====
module paee_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/paee_engine.sv =====
module paee_engine #(
    parameter int QUEUE_DEPTH = 64,
    parameter int PRIO_LEVELS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  paee_pkg::item_t   in_item,
    output logic              res_valid,
    input  logic              res_ready,
    output paee_pkg::result_t res
);

    localparam int IDX_W     = $clog2(QUEUE_DEPTH);
    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int LVL_W     = $clog2(PRIO_LEVELS);
    localparam int ENTRY_W   = paee_pkg::TAG_W + LVL_W + paee_pkg::STAT_W;
    localparam int RAM_DEPTH = 2 * (2 ** IDX_W);
    localparam int AW        = IDX_W + 1;
    localparam int DYN_LO    = paee_pkg::TAG_W;
    localparam int DYN_HI    = paee_pkg::TAG_W + LVL_W - 1;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [6:0] MAX_LVL = 7'(PRIO_LEVELS - 1);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_SHIFT, S_EMIT} state_t;

    state_t               state_reg, state_next;
    logic                 act_b_reg, act_b_next;
    logic [CNT_W-1:0]     cnt_a_reg, cnt_a_next;
    logic [CNT_W-1:0]     cnt_b_reg, cnt_b_next;
    logic [CNT_W-1:0]     n_reg, n_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [IDX_W-1:0]     best_idx_reg, best_idx_next;
    logic [ENTRY_W-1:0]   best_reg, best_next;
    logic                 bank_reg, bank_next;
    paee_pkg::result_t    res_reg, res_next;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [ENTRY_W-1:0]   ram_wdata;
    logic [AW-1:0]        ram_raddr;
    logic [ENTRY_W-1:0]   ram_rdata;

    logic                 add_target;
    logic [CNT_W-1:0]     add_cnt;
    logic [6:0]           lvl_raw;
    logic [6:0]           lvl_sat;
    logic                 take_bank;
    logic [CNT_W-1:0]     take_cnt;
    logic                 take_it;
    logic [CNT_W-1:0]     n_m1;

    function automatic paee_pkg::result_t idle_res(paee_pkg::status_t st);
        paee_pkg::result_t r;
        r.status = st;
        r.tag    = '0;
        r.dyn    = '0;
        r.stat   = paee_pkg::STAT_W'(1);
        return r;
    endfunction

    function automatic paee_pkg::result_t grant_res(logic [ENTRY_W-1:0] e);
        paee_pkg::result_t                   r;
        logic [paee_pkg::GDYN_W+LVL_W-1:0]   ext;
        ext      = {{paee_pkg::GDYN_W{1'b0}}, e[DYN_HI:DYN_LO]};
        r.status = paee_pkg::ST_GRANTED;
        r.tag    = e[paee_pkg::TAG_W-1:0];
        r.dyn    = ext[paee_pkg::GDYN_W-1:0];
        r.stat   = e[ENTRY_W-1:DYN_HI+1];
        return r;
    endfunction

    paee_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // level written for an add: clamped dynamic level, or static - 1 on refill
    always_comb begin
        if (!in_item.dyn[paee_pkg::DYN_IN_W-1]) begin
            lvl_raw = {2'b00, in_item.dyn[paee_pkg::DYN_IN_W-1:0]};
        end else if (in_item.stat == '0) begin
            lvl_raw = '0;
        end else begin
            lvl_raw = {2'b00, in_item.stat} - 7'd1;
        end
        lvl_sat = (lvl_raw > MAX_LVL) ? MAX_LVL : lvl_raw;
    end

    assign add_target = in_item.dyn[paee_pkg::DYN_IN_W-1] ? ~act_b_reg : act_b_reg;
    assign add_cnt    = add_target ? cnt_b_reg : cnt_a_reg;
    assign take_bank  = (((act_b_reg ? cnt_b_reg : cnt_a_reg) == '0)) ? ~act_b_reg : act_b_reg;
    assign take_cnt   = take_bank ? cnt_b_reg : cnt_a_reg;
    assign n_m1       = n_reg - CNT_W'(1);
    assign take_it    = (idx_reg == '0) || (ram_rdata[DYN_HI:DYN_LO] > best_reg[DYN_HI:DYN_LO]);

    always_comb begin
        state_next    = state_reg;
        act_b_next    = act_b_reg;
        cnt_a_next    = cnt_a_reg;
        cnt_b_next    = cnt_b_reg;
        n_next        = n_reg;
        idx_next      = idx_reg;
        best_idx_next = best_idx_reg;
        best_next     = best_reg;
        bank_next     = bank_reg;
        res_next      = res_reg;
        ram_we        = 1'b0;
        ram_waddr     = {bank_reg, idx_reg};
        ram_wdata     = ram_rdata;
        ram_raddr     = {bank_reg, idx_reg + IDX_W'(1)};
        in_ready      = 1'b0;
        res_valid     = 1'b0;

        case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    if (in_item.kind == paee_pkg::KIND_ADD) begin
                        state_next = S_EMIT;
                        if (add_cnt == FULL_CNT) begin
                            res_next = idle_res(paee_pkg::ST_DROPPED);
                        end else begin
                            ram_we    = 1'b1;
                            ram_waddr = {add_target, add_cnt[IDX_W-1:0]};
                            ram_wdata = {in_item.stat, lvl_sat[LVL_W-1:0], in_item.tag};
                            if (add_target) begin
                                cnt_b_next = cnt_b_reg + CNT_W'(1);
                            end else begin
                                cnt_a_next = cnt_a_reg + CNT_W'(1);
                            end
                            res_next = idle_res(in_item.dyn[paee_pkg::DYN_IN_W-1] ?
                                paee_pkg::ST_QUEUED_EXPIRED : paee_pkg::ST_QUEUED_ACTIVE);
                        end
                    end else begin
                        act_b_next = take_bank;
                        bank_next  = take_bank;
                        n_next     = take_cnt;
                        idx_next   = '0;
                        ram_raddr  = {take_bank, {IDX_W{1'b0}}};
                        if (take_cnt == '0) begin
                            res_next   = idle_res(paee_pkg::ST_EMPTY);
                            state_next = S_EMIT;
                        end else begin
                            state_next = S_SCAN;
                        end
                    end
                end
            end
            S_SCAN: begin
                // ram_rdata holds entry idx_reg; strict compare keeps the earliest
                if (take_it) begin
                    best_next     = ram_rdata;
                    best_idx_next = idx_reg;
                end
                if (CNT_W'(idx_reg) == n_m1) begin
                    if (CNT_W'(best_idx_next) == n_m1) begin
                        if (bank_reg) begin
                            cnt_b_next = n_m1;
                        end else begin
                            cnt_a_next = n_m1;
                        end
                        res_next   = grant_res(best_next);
                        state_next = S_EMIT;
                    end else begin
                        ram_raddr  = {bank_reg, best_idx_next + IDX_W'(1)};
                        idx_next   = best_idx_next;
                        state_next = S_SHIFT;
                    end
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            S_SHIFT: begin
                // ram_rdata holds entry idx_reg + 1, moved down one place
                ram_we    = 1'b1;
                ram_waddr = {bank_reg, idx_reg};
                ram_wdata = ram_rdata;
                if (CNT_W'(idx_reg) + CNT_W'(1) == n_m1) begin
                    if (bank_reg) begin
                        cnt_b_next = n_m1;
                    end else begin
                        cnt_a_next = n_m1;
                    end
                    res_next   = grant_res(best_reg);
                    state_next = S_EMIT;
                end else begin
                    ram_raddr = {bank_reg, idx_reg + IDX_W'(2)};
                    idx_next  = idx_reg + IDX_W'(1);
                end
            end
            S_EMIT: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            act_b_reg <= 1'b0;
            cnt_a_reg <= '0;
            cnt_b_reg <= '0;
        end else begin
            state_reg    <= state_next;
            act_b_reg    <= act_b_next;
            cnt_a_reg    <= cnt_a_next;
            cnt_b_reg    <= cnt_b_next;
            n_reg        <= n_next;
            idx_reg      <= idx_next;
            best_idx_reg <= best_idx_next;
            best_reg     <= best_next;
            bank_reg     <= bank_next;
            res_reg      <= res_next;
        end
    end

endmodule

// ===== rtl/core/priority_active_expired_scheduler.sv =====
// add, or take on two empty banks: result passes S_EMIT and the output register to m_tvalid
// take of n entries, winner at index w: n scan reads plus n-1-w compaction steps,
// then S_EMIT and the output register as for an add
// s_tready rises as the result enters the output register, so one item in work
// aresetn (synchronous, active low) empties both banks and makes bank a active;
// entry ram contents stay undefined, no clearing pass
module priority_active_expired_scheduler #(
    parameter int QUEUE_DEPTH = 64,
    parameter int PRIO_LEVELS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // task_tag[15:0], dynamic_level[20:16], static_level[25:21]
    input  logic [0:0]  s_tuser,   // kind[0]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // granted_tag[15:0], granted_dynamic[19:16],
                                   // granted_static[24:20]
    output logic [2:0]  m_tuser    // status[2:0]
);

    paee_pkg::item_t   in_item;
    paee_pkg::result_t eng_res;
    logic              eng_res_valid;
    logic              eng_res_ready;

    // output register
    logic              m_tvalid_reg, m_tvalid_next;
    paee_pkg::result_t out_reg, out_next;

    // unpack the input transfer
    assign in_item.kind = s_tuser[0];
    assign in_item.tag  = s_tdata[15:0];
    assign in_item.dyn  = s_tdata[20:16];
    assign in_item.stat = s_tdata[25:21];

    // sequencer around the entry ram: add, scan for the maximum, compaction
    paee_engine #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .PRIO_LEVELS (PRIO_LEVELS)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (in_item),
        .res_valid (eng_res_valid),
        .res_ready (eng_res_ready),
        .res       (eng_res)
    );

    // the result register takes a new result when empty or being drained
    assign eng_res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        out_next      = out_reg;
        if (eng_res_valid && eng_res_ready) begin
            m_tvalid_next = 1'b1;
            out_next      = eng_res;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
            out_reg      <= out_next;
        end
    end

    // pack the result transfer
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {7'b0, out_reg.stat, out_reg.dyn, out_reg.tag};

endmodule

// ===== rtl/core/paee_checker.sv =====
`include "priority_active_expired_scheduler_defines.svh"

module paee_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [2:0]  m_tuser
);

    // a stalled result holds
    `PAEE_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    // anything but a grant carries tag 0, dynamic 0, static 1
    `PAEE_ASSERT_IMPLY(a_idle_payload, aclk, aresetn, m_tvalid && (m_tuser != 3'(paee_pkg::ST_GRANTED)), m_tdata == 32'h0010_0000, "non-grant result payload wrong")

    // one item at a time: no transfer right after a transfer
    `PAEE_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_tvalid && s_tready, !s_tready, "input taken while busy")

    // reset drops any pending result
    `PAEE_ASSERT_NEXT_ALWAYS(a_reset_clear, aclk, !aresetn, !m_tvalid, "result valid after reset")

endmodule

bind priority_active_expired_scheduler paee_checker u_paee_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== dv/paee_grant_checker.sv =====
`timescale 1ns / 1ps

module paee_grant_checker
    import paee_pkg::*;
#(
    parameter int QUEUE_DEPTH = 64,
    parameter int PRIO_LEVELS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,   // task_tag[15:0], dynamic_level[20:16], static_level[25:21]
    input  logic [0:0]  s_tuser,   // kind[0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // granted_tag[15:0], granted_dynamic[19:16],
                                   // granted_static[24:20]
    input  logic [2:0]  m_tuser,   // status[2:0]
    output int          mismatch_count,
    output int          results_owed,
    output int          n_items,
    output int          n_grants,
    output int          n_empty,
    output int          n_drops,
    output int          n_swaps,
    output int          peak_fill
);

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [GDYN_W-1:0] dyn;
        logic [STAT_W-1:0] stat;
    } entry_t;

    entry_t  bank_mem [2][QUEUE_DEPTH];
    int      bank_cnt [2];
    logic    active_b;
    result_t grant_q[$];
    int      n_results;

    // one scheduling decision: updates the bank copy and returns the outcome
    function automatic result_t schedule_item(input logic kind, input logic [TAG_W-1:0] tag,
                                              input logic signed [DYN_IN_W-1:0] lvl_in,
                                              input logic [STAT_W-1:0] stat);
        result_t r;
        entry_t  e;
        int      tgt;
        int      lvl;
        int      n;
        int      best;
        int      i;
        r.status = ST_EMPTY;
        r.tag    = '0;
        r.dyn    = '0;
        r.stat   = STAT_W'(1);
        if (kind == KIND_ADD) begin
            e.tag  = tag;
            e.stat = stat;
            if (lvl_in >= 0) begin
                tgt      = int'(active_b);
                lvl      = int'(lvl_in);
                r.status = ST_QUEUED_ACTIVE;
            end else begin
                // exhausted: refill from the static level into the other bank
                tgt      = int'(!active_b);
                lvl      = int'(stat) - 1;
                r.status = ST_QUEUED_EXPIRED;
            end
            if (lvl < 0) lvl = 0;
            if (lvl > PRIO_LEVELS - 1) lvl = PRIO_LEVELS - 1;
            e.dyn = GDYN_W'(lvl);
            if (bank_cnt[tgt] >= QUEUE_DEPTH) begin
                r.status = ST_DROPPED;
                n_drops++;
            end else begin
                bank_mem[tgt][bank_cnt[tgt]] = e;
                bank_cnt[tgt]++;
                if (bank_cnt[tgt] > peak_fill) peak_fill = bank_cnt[tgt];
            end
            return r;
        end
        if (bank_cnt[active_b] == 0) begin
            active_b = !active_b;
            if (bank_cnt[active_b] != 0) n_swaps++;
        end
        n = bank_cnt[active_b];
        if (n == 0) begin
            n_empty++;
            return r;
        end
        // earliest entry among the highest levels wins
        best = 0;
        for (i = 1; i < n; i++) begin
            if (bank_mem[active_b][i].dyn > bank_mem[active_b][best].dyn) best = i;
        end
        r.status = ST_GRANTED;
        r.tag    = bank_mem[active_b][best].tag;
        r.dyn    = bank_mem[active_b][best].dyn;
        r.stat   = bank_mem[active_b][best].stat;
        for (i = best; i < n - 1; i++) begin
            bank_mem[active_b][i] = bank_mem[active_b][i + 1];
        end
        bank_cnt[active_b] = n - 1;
        n_grants++;
        return r;
    endfunction

    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            bank_cnt[0] = 0;
            bank_cnt[1] = 0;
            active_b    = 1'b0;
            grant_q.delete();
            results_owed <= 0;
        end else begin
            // results first, so a result can never match an item taken at the same edge
            if (m_tvalid && m_tready) begin
                n_results++;
                if (grant_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("[%0t] result %0d arrived with nothing outstanding: status %0d tag %h",
                                 $realtime, n_results, m_tuser, m_tdata[15:0]);
                end else begin
                    want = grant_q.pop_front();
                    if (m_tuser !== want.status || m_tdata[15:0] !== want.tag ||
                        m_tdata[19:16] !== want.dyn || m_tdata[24:20] !== want.stat) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("[%0t] result %0d: expected %0d/%h/%0d/%0d got %0d/%h/%0d/%0d",
                                     $realtime, n_results, want.status, want.tag, want.dyn,
                                     want.stat, m_tuser, m_tdata[15:0], m_tdata[19:16],
                                     m_tdata[24:20]);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                n_items++;
                grant_q.insert(grant_q.size(), schedule_item(s_tuser[0], s_tdata[15:0],
                                                             s_tdata[20:16], s_tdata[25:21]));
            end
            results_owed <= grant_q.size();
        end
    end

endmodule

// ===== dv/tb_priority_active_expired_scheduler.sv =====
`timescale 1ns / 1ps

module tb_priority_active_expired_scheduler;

    import paee_pkg::*;

    localparam int QUEUE_DEPTH = 64;
    localparam int PRIO_LEVELS = 16;
    localparam int CLK_HALF    = 5;
    localparam int ITEM_TARGET = 1750;

    // dynamic level encodings used by the directed part
    localparam logic [DYN_IN_W-1:0] LVL_EXHAUSTED = 5'h1f;   // -1
    localparam logic [DYN_IN_W-1:0] LVL_MOST_NEG  = 5'h10;   // -16
    localparam logic [DYN_IN_W-1:0] LVL_TOP       = 5'd15;

    typedef enum int {PH_MIXED, PH_FILL_ACTIVE, PH_FILL_EXPIRED, PH_DRAIN} phase_e;
    typedef enum int {RX_STEADY, RX_RANDOM, RX_PERIODIC} rx_e;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // task_tag[15:0], dynamic_level[20:16], static_level[25:21]
    logic [0:0]  s_tuser  = '0;   // kind[0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // granted_tag[15:0], granted_dynamic[19:16],
                                  // granted_static[24:20]
    logic [2:0]  m_tuser;         // status[2:0]

    int mismatch_count;
    int results_owed;
    int n_items;
    int n_grants;
    int n_empty;
    int n_drops;
    int n_swaps;
    int peak_fill;

    // sender state: items handed over so far, burst bookkeeping
    int sent       = 0;
    int burst_left = 0;
    bit gaps_on    = 1'b1;

    // receiver stall pattern
    rx_e rx_mode = RX_STEADY;
    int  rx_left = 0;

    always #CLK_HALF aclk = ~aclk;

    priority_active_expired_scheduler #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .PRIO_LEVELS(PRIO_LEVELS)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    paee_grant_checker #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .PRIO_LEVELS(PRIO_LEVELS)
    ) checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .mismatch_count(mismatch_count),
        .results_owed  (results_owed),
        .n_items       (n_items),
        .n_grants      (n_grants),
        .n_empty       (n_empty),
        .n_drops       (n_drops),
        .n_swaps       (n_swaps),
        .peak_fill     (peak_fill)
    );

    // receiver: switches between always ready, random stalls and a fixed
    // ready/stall rhythm each time its random mode counter runs out
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode <= rx_e'($urandom_range(0, 2));
            rx_left <= $urandom_range(40, 400);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_STEADY: m_tready <= 1'b1;
            RX_RANDOM: m_tready <= ($urandom_range(0, 2) != 0);
            default:   m_tready <= ((rx_left % 7) < 3);
        endcase
    end

    // one input transfer; valid stays high into the next item unless a gap
    // closes the burst
    task automatic send_item(input logic kind, input logic [TAG_W-1:0] tag,
                             input logic [DYN_IN_W-1:0] lvl, input logic [STAT_W-1:0] stat);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {6'b0, stat, lvl, tag};
        do @(posedge aclk); while (s_tready !== 1'b1);
        sent++;
        if (gaps_on) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                s_tvalid <= 1'b0;
                // mostly short gaps, now and then one that spans a whole take
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(20, 150)) @(posedge aclk);
                else
                    repeat ($urandom_range(1, 8)) @(posedge aclk);
                burst_left = $urandom_range(0, 15);
            end
        end
    endtask

    // hold the sender off until every outstanding result has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_owed != 0) @(posedge aclk);
    endtask

    // dynamic level for an add: mostly the intended class, sometimes any encoding
    function automatic logic [DYN_IN_W-1:0] pick_level(input bit exhausted);
        if ($urandom_range(0, 9) == 0) return DYN_IN_W'($urandom);
        if (exhausted)
            return ($urandom_range(0, 2) != 0) ? LVL_EXHAUSTED : DYN_IN_W'($urandom_range(16, 31));
        return DYN_IN_W'($urandom_range(0, PRIO_LEVELS - 1));
    endfunction

    // static level: mostly legal, sometimes out of range (0, 17..31)
    function automatic logic [STAT_W-1:0] pick_static();
        if ($urandom_range(0, 7) == 0) return STAT_W'($urandom_range(0, 31));
        return STAT_W'($urandom_range(1, PRIO_LEVELS));
    endfunction

    task automatic add_task(input bit exhausted);
        send_item(KIND_ADD, TAG_W'($urandom), pick_level(exhausted), pick_static());
    endtask

    // take carries random payload bits, which the block must ignore
    task automatic take_next();
        send_item(KIND_TAKE, TAG_W'($urandom), DYN_IN_W'($urandom), STAT_W'($urandom));
    endtask

    initial begin
        phase_e ph;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: take on two empty banks first
        send_item(KIND_TAKE, 16'h0000, '0, '0);
        // extremes into the active bank, with a tie at the top level
        send_item(KIND_ADD, 16'h0000, 5'd0, 5'd1);
        send_item(KIND_ADD, 16'hffff, LVL_TOP, 5'd16);
        send_item(KIND_ADD, 16'haaaa, LVL_TOP, 5'd3);
        // exhausted entries refilled from static level, including saturation, and one active add
        send_item(KIND_ADD, 16'h5555, LVL_EXHAUSTED, 5'd16);
        send_item(KIND_ADD, 16'h0001, LVL_MOST_NEG, 5'd0);
        send_item(KIND_ADD, 16'h8000, 5'd7, 5'd31);
        send_item(KIND_ADD, 16'h7fff, LVL_EXHAUSTED, 5'd20);
        // drain the active bank, then a take that swaps banks
        repeat (5) send_item(KIND_TAKE, 16'hffff, 5'h1f, 5'h1f);
        // one add to each bank after the swap
        send_item(KIND_ADD, 16'h1111, LVL_EXHAUSTED, 5'd1);
        send_item(KIND_ADD, 16'h2222, 5'd3, 5'd9);
        // empty both banks through a second swap, then two empty takes
        repeat (6) send_item(KIND_TAKE, 16'h0000, '0, '0);

        // at least one full stop with everything answered
        wait_drained();

        // random phases: mixed traffic, overflow of either bank, long drains
        while (sent < ITEM_TARGET) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            ph = ($urandom_range(0, 1) != 0) ? PH_MIXED : phase_e'($urandom_range(0, 3));
            case (ph)
                PH_FILL_ACTIVE: begin
                    repeat (QUEUE_DEPTH + $urandom_range(1, 6)) add_task(1'b0);
                end
                PH_FILL_EXPIRED: begin
                    repeat (QUEUE_DEPTH + $urandom_range(1, 6)) add_task(1'b1);
                end
                PH_DRAIN: begin
                    repeat ($urandom_range(30, 2 * QUEUE_DEPTH + 8)) take_next();
                end
                default: begin
                    repeat ($urandom_range(20, 80)) begin
                        if ($urandom_range(0, 9) < 6)
                            add_task($urandom_range(0, 3) == 0);
                        else
                            take_next();
                    end
                end
            endcase
            if ($urandom_range(0, 3) == 0) wait_drained();
        end

        // wait out the last results, then a full worst-case take longer
        wait_drained();
        repeat (2 * QUEUE_DEPTH + 10) @(posedge aclk);

        $display("run covered %0d transfers: %0d grants, %0d empty takes, %0d dropped adds",
                 n_items, n_grants, n_empty, n_drops);
        $display("bank role swaps: %0d, deepest bank fill: %0d of %0d",
                 n_swaps, peak_fill, QUEUE_DEPTH);
        if (mismatch_count == 0 && results_owed == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial begin
        #(10_000_000);
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/paee_pkg.sv
rtl/core/paee_ram.sv
rtl/core/paee_engine.sv
rtl/core/priority_active_expired_scheduler.sv
rtl/core/paee_checker.sv
dv/paee_grant_checker.sv
dv/tb_priority_active_expired_scheduler.sv
